// File: rtl/core/stm_pkg.sv
// Shared constants, types and the quarter-wave sine table of the tone generator.
// No dependencies; the other files that use it refer to it by scoped names.
package stm_pkg;

  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int TBL_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int MAX_CHANNELS     = 8;

  localparam int MUL_WIDTH    = 32;
  localparam int MUL_CNT_BITS = $clog2(MUL_WIDTH);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q15     = 64'd32768;

  localparam logic [14:0] VOL_MAX  = 15'd16384;
  localparam logic [31:0] FULL_S16 = 32'd32767;
  localparam logic [31:0] FULL_S24 = 32'd8388607;
  localparam logic [31:0] FULL_Q31 = 32'd2147483647;

  typedef enum logic [1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_VOLUME        = 2'd1,
    REG_NUM_CHANS     = 2'd2,
    REG_SAMPLE_FORMAT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_S16 = 2'd0,
    FMT_S24 = 2'd1,
    FMT_Q31 = 2'd2
  } fmt_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_VOL,
    C_SIN,
    C_FULL,
    C_HOLD
  } cstate_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_WIDTH-1:0] a;
    logic [MUL_WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [2*MUL_WIDTH-1:0] product;
  } mul_rsp_t;

  typedef logic [SINE_TABLE_DEPTH:0][15:0] rom_t;

  function automatic rom_t build_sine_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum  = sum - term;
      q    = (sum + 64'd16384) >> 15;
      if (q > ONE_Q15) begin
        q = ONE_Q15;
      end
      rom[i] = q[15:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/stm_if.sv
// Valid/ready channels of the tone generator: frame requests in, sample beats out.
// Depends on nothing.
interface stm_req_if;
  logic valid;
  logic ready;
  logic frame_request;

  modport source (output valid, output frame_request, input ready);
  modport sink   (input valid, input frame_request, output ready);
endinterface

interface stm_smp_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] sample;
  logic        [2:0] channel_index;
  logic              last_in_frame;

  modport source (output valid, output sample, output channel_index,
                  output last_in_frame, input ready);
  modport sink   (input valid, input sample, input channel_index,
                  input last_in_frame, output ready);
endinterface

// File: rtl/core/stm_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MUL_WIDTH steps.
// Depends on stm_pkg.
module stm_mul (
  input  logic              clk,
  input  logic              rst,
  input  stm_pkg::mul_req_t req,
  output stm_pkg::mul_rsp_t rsp
);

  logic [stm_pkg::MUL_WIDTH-1:0]    mcand;
  logic [2*stm_pkg::MUL_WIDTH-1:0]  prod;
  logic [stm_pkg::MUL_CNT_BITS-1:0] cnt;
  logic                             busy;
  logic                             done;
  logic [stm_pkg::MUL_WIDTH:0]      sum;

  assign sum = {1'b0, prod[2*stm_pkg::MUL_WIDTH-1:stm_pkg::MUL_WIDTH]}
             + (prod[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == stm_pkg::MUL_CNT_BITS'(stm_pkg::MUL_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand <= req.a;
      prod  <= {{stm_pkg::MUL_WIDTH{1'b0}}, req.b};
    end else if (busy) begin
      prod <= {sum, prod[stm_pkg::MUL_WIDTH-1:1]};
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = prod;

endmodule

// File: rtl/core/sine_tone_generator.sv
// Sine tone generator top level: config registers, phase accumulator, sequencer.
// Depends on stm_pkg, stm_if.sv (channels) and stm_mul.
// A frame request is taken while the sequencer is idle; the sample is built from the
// phase held at that moment, then the phase advances by phase_step. Three passes of
// one shared bit-serial multiplier (volume squared, times sine, times full scale) set
// the latency. The result waits until the previous frame's beats are out; the first beat
// is offered in the same cycle that the sequencer is idle for the next request. Beats
// leave one per cycle while tone.ready is high, from an output register, while the
// next frame computes. A request with frame_request low is taken and dropped.
module sine_tone_generator (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  stm_req_if.sink          req,
  stm_smp_if.source        tone
);

  logic [31:0] phase_step;
  logic [14:0] volume;
  logic [3:0]  num_chans;
  logic [1:0]  sample_format;

  logic [stm_pkg::PHASE_BITS-1:0] phase;

  stm_pkg::cstate_t  state;
  stm_pkg::cstate_t  state_next;
  stm_pkg::mul_req_t mreq;
  stm_pkg::mul_rsp_t mrsp;

  logic        take;
  logic        load_res;
  logic        xfer;
  logic        ready;

  logic [15:0] mag;
  logic        neg;
  logic [31:0] res;
  logic [31:0] word_out;
  logic [2:0]  ch;
  logic [2:0]  n_last;
  logic        out_busy;

  logic [1:0]                   quad;
  logic [stm_pkg::TBL_BITS-1:0] idx;
  logic [stm_pkg::TBL_BITS:0]   ridx;
  logic [14:0]                  vol_sat;
  logic [31:0]                  full;
  logic [3:0]                   n_sat;
  logic [31:0]                  word;

  stm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= 32'd23353885;
      volume        <= '0;
      num_chans     <= 4'd2;
      sample_format <= stm_pkg::FMT_S16;
    end else if (cfg_write) begin
      case (stm_pkg::cfg_reg_t'(cfg_index))
        stm_pkg::REG_PHASE_STEP:    phase_step    <= cfg_data;
        stm_pkg::REG_VOLUME:        volume        <= cfg_data[14:0];
        stm_pkg::REG_NUM_CHANS:     num_chans     <= cfg_data[3:0];
        stm_pkg::REG_SAMPLE_FORMAT: sample_format <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign quad = phase[stm_pkg::PHASE_BITS-1 -: 2];
  assign idx  = phase[stm_pkg::PHASE_BITS-3 -: stm_pkg::TBL_BITS];
  assign ridx = quad[0] ? (stm_pkg::TBL_BITS+1)'(stm_pkg::SINE_TABLE_DEPTH) - {1'b0, idx}
                        : {1'b0, idx};

  assign vol_sat = (volume > stm_pkg::VOL_MAX) ? stm_pkg::VOL_MAX : volume;

  always_comb begin
    case (stm_pkg::fmt_t'(sample_format))
      stm_pkg::FMT_S16: full = stm_pkg::FULL_S16;
      stm_pkg::FMT_S24: full = stm_pkg::FULL_S24;
      stm_pkg::FMT_Q31: full = stm_pkg::FULL_Q31;
      default:          full = stm_pkg::FULL_Q31;
    endcase
  end

  always_comb begin
    if (num_chans == '0) begin
      n_sat = 4'd1;
    end else if (num_chans > 4'(stm_pkg::MAX_CHANNELS)) begin
      n_sat = 4'(stm_pkg::MAX_CHANNELS);
    end else begin
      n_sat = num_chans;
    end
  end

  assign word = mrsp.product[31 +: 32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stm_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mreq       = '0;
    ready      = 1'b0;
    take       = 1'b0;
    load_res   = 1'b0;
    xfer       = 1'b0;
    case (state)
      stm_pkg::C_IDLE: begin
        ready  = 1'b1;
        mreq.a = 32'(vol_sat);
        mreq.b = 32'(vol_sat);
        if (req.valid && req.frame_request) begin
          take       = 1'b1;
          mreq.start = 1'b1;
          state_next = stm_pkg::C_VOL;
        end
      end
      stm_pkg::C_VOL: begin
        mreq.a = 32'(mrsp.product[28:0]);
        mreq.b = 32'(mag);
        if (mrsp.done) begin
          mreq.start = 1'b1;
          state_next = stm_pkg::C_SIN;
        end
      end
      stm_pkg::C_SIN: begin
        mreq.a = full;
        mreq.b = 32'(mrsp.product[14 +: 30]);
        if (mrsp.done) begin
          mreq.start = 1'b1;
          state_next = stm_pkg::C_FULL;
        end
      end
      stm_pkg::C_FULL: begin
        if (mrsp.done) begin
          load_res   = 1'b1;
          state_next = stm_pkg::C_HOLD;
        end
      end
      stm_pkg::C_HOLD: begin
        if (!out_busy) begin
          xfer       = 1'b1;
          state_next = stm_pkg::C_IDLE;
        end
      end
      default: state_next = stm_pkg::C_IDLE;
    endcase
  end

  assign req.ready = ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (take) begin
      phase <= phase + stm_pkg::PHASE_BITS'(phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag <= stm_pkg::SINE_ROM[ridx];
      neg <= quad[1];
    end
    if (load_res) begin
      res <= neg ? (32'd0 - word) : word;
    end
    if (xfer) begin
      word_out <= res;
      n_last   <= 3'(n_sat - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      ch       <= '0;
    end else if (xfer) begin
      out_busy <= 1'b1;
      ch       <= '0;
    end else if (out_busy && tone.ready) begin
      if (ch == n_last) begin
        out_busy <= 1'b0;
      end else begin
        ch <= ch + 3'd1;
      end
    end
  end

  assign tone.valid         = out_busy;
  assign tone.sample        = word_out;
  assign tone.channel_index = ch;
  assign tone.last_in_frame = (ch == n_last);

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mrsp.busy)
    else $error("multiplier restarted while busy");

  a_idle_mul: assert property (@(posedge clk) disable iff (rst)
    (state == stm_pkg::C_IDLE) |-> !mrsp.busy)
    else $error("sequencer idle with multiplier running");

  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (out_busy && tone.ready && tone.last_in_frame) |=> !out_busy)
    else $error("beats continue after last channel");

  a_xfer: assert property (@(posedge clk) disable iff (rst)
    xfer |=> (out_busy && ch == 3'd0))
    else $error("frame handoff did not start at channel zero");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    out_busy |-> (ch <= n_last))
    else $error("channel index beyond frame");

endmodule
